>>> rtl/assert_macros.svh
// Assertion macros for the RTL, used by ttc_queue. They compile to nothing when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(name, clk, rst, prop)
`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`endif
`endif

>>> rtl/ttc_pkg.sv
package ttc_pkg;

   localparam int MAX_TEXT = 4096;
   localparam int POS_W = 13;
   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TEXT);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] CLS_KEYWORD = 3'd0;
   localparam logic [2:0] CLS_KEY = 3'd1;
   localparam logic [2:0] CLS_VALUE = 3'd2;
   localparam logic [2:0] CLS_NUMBER = 3'd3;
   localparam logic [2:0] CLS_PUNCT = 3'd4;

   localparam logic [3:0] KW_LEN = 4'd6;
   localparam logic [3:0] KW_FAIL = 4'd15;

   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;

   typedef struct packed {
      logic [POS_W-1:0] start;
      logic [POS_W-1:0] stop;
      logic [2:0] cls;
   } token_type;

   // All results caused by one input byte; the second token is used when two is set.
   typedef struct packed {
      token_type first;
      token_type second;
      logic two;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
             (c == 8'h5f);
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return (c == 8'h7b) || (c == 8'h7d) || (c == 8'h5b) || (c == 8'h5d) ||
             (c == 8'h2c) || (c == CH_COLON) || (c == 8'h3d);
   endfunction

   function automatic logic [7:0] kw_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h63;
         3'd1: ch = 8'h6f;
         3'd2: ch = 8'h6e;
         3'd3: ch = 8'h66;
         3'd4: ch = 8'h69;
         3'd5: ch = 8'h67;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [3:0] kw_advance(input logic [3:0] km, input logic [7:0] c);
      logic [3:0] res;
      if ((km < KW_LEN) && (c == kw_char(km[2:0]))) begin
         res = km + 4'd1;
      end else begin
         res = KW_FAIL;
      end
      return res;
   endfunction

   function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
      return (p >= MAX_POS) ? MAX_POS : p + POS_W'(1);
   endfunction

endpackage

>>> rtl/ttc_front.sv
module ttc_front (
   input  logic clock,
   input  logic reset,
   input  logic [7:0] req_text_byte,
   input  logic req_text_end,
   input  logic req_push,
   output logic req_full,
   input  ttc_pkg::q_status_type q_status,
   output logic q_push,
   output ttc_pkg::entry_type q_entry
);

   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_STR = 3'd1;
   localparam logic [2:0] MODE_ESC = 3'd2;
   localparam logic [2:0] MODE_AFTER = 3'd3;
   localparam logic [2:0] MODE_NUM = 3'd4;
   localparam logic [2:0] MODE_IDENT = 3'd5;

   logic [2:0] mode_ff, mode_in, mode_mid;
   logic [ttc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [ttc_pkg::POS_W-1:0] start_ff, start_in, start_mid;
   logic quote_ff, quote_in, quote_mid;
   logic [3:0] kw_ff, kw_in, kw_mid;
   logic [ttc_pkg::POS_W-1:0] pend_ff, pend_in, pend_mid;

   logic accept;
   logic [7:0] c;
   logic [ttc_pkg::POS_W-1:0] nxt;
   logic [7:0] close_quote;
   logic take;
   logic close_v, punct_v, end_v;
   ttc_pkg::token_type close_tok, punct_tok, end_tok;

   assign req_full = q_status.full;
   assign accept = req_push && !q_status.full;
   assign c = req_text_byte;
   assign nxt = ttc_pkg::sat_inc(pos_ff);
   assign close_quote = quote_ff ? ttc_pkg::CH_SQUOTE : ttc_pkg::CH_DQUOTE;

   always_comb begin
      mode_mid = mode_ff;
      start_mid = start_ff;
      quote_mid = quote_ff;
      kw_mid = kw_ff;
      pend_mid = pend_ff;
      close_v = 1'b0;
      close_tok.start = start_ff;
      close_tok.stop = pos_ff;
      close_tok.cls = ttc_pkg::CLS_NUMBER;
      take = 1'b0;
      punct_v = 1'b0;
      end_v = 1'b0;
      end_tok.start = start_ff;
      end_tok.stop = nxt;
      end_tok.cls = ttc_pkg::CLS_VALUE;

      case (mode_ff)
         MODE_STR: begin
            if (c == ttc_pkg::CH_BSLASH) begin
               mode_mid = MODE_ESC;
            end else if (c == close_quote) begin
               pend_mid = nxt;
               mode_mid = MODE_AFTER;
            end
         end
         MODE_ESC: begin
            mode_mid = MODE_STR;
         end
         MODE_AFTER: begin
            if ((c != ttc_pkg::CH_SPACE) && (c != ttc_pkg::CH_TAB)) begin
               close_v = 1'b1;
               close_tok.stop = pend_ff;
               close_tok.cls = (c == ttc_pkg::CH_COLON) ? ttc_pkg::CLS_KEY
                                                        : ttc_pkg::CLS_VALUE;
               take = 1'b1;
            end
         end
         MODE_NUM: begin
            if (!ttc_pkg::is_digit(c)) begin
               close_v = 1'b1;
               take = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (ttc_pkg::is_alpha(c) || ttc_pkg::is_digit(c)) begin
               kw_mid = ttc_pkg::kw_advance(kw_ff, c);
            end else begin
               close_v = (kw_ff == ttc_pkg::KW_LEN);
               close_tok.cls = ttc_pkg::CLS_KEYWORD;
               take = 1'b1;
            end
         end
         default: begin
            take = 1'b1;
         end
      endcase

      // A byte that closes a token, or arrives with none open, may start the next one.
      if (take) begin
         mode_mid = MODE_IDLE;
         if ((c == ttc_pkg::CH_DQUOTE) || (c == ttc_pkg::CH_SQUOTE)) begin
            mode_mid = MODE_STR;
            start_mid = pos_ff;
            quote_mid = (c == ttc_pkg::CH_SQUOTE);
         end else if (ttc_pkg::is_digit(c)) begin
            mode_mid = MODE_NUM;
            start_mid = pos_ff;
         end else if (ttc_pkg::is_alpha(c)) begin
            mode_mid = MODE_IDENT;
            start_mid = pos_ff;
            kw_mid = ttc_pkg::kw_advance(4'd0, c);
         end else if (ttc_pkg::is_punct(c)) begin
            punct_v = 1'b1;
         end
      end

      end_tok.start = start_mid;
      if (req_text_end) begin
         case (mode_mid)
            MODE_STR, MODE_ESC: begin
               end_v = 1'b1;
            end
            MODE_AFTER: begin
               end_v = 1'b1;
               end_tok.stop = pend_mid;
            end
            MODE_NUM: begin
               end_v = 1'b1;
               end_tok.cls = ttc_pkg::CLS_NUMBER;
            end
            MODE_IDENT: begin
               end_v = (kw_mid == ttc_pkg::KW_LEN);
               end_tok.cls = ttc_pkg::CLS_KEYWORD;
            end
            default: begin
               end_v = 1'b0;
            end
         endcase
      end
   end

   assign punct_tok.start = pos_ff;
   assign punct_tok.stop = nxt;
   assign punct_tok.cls = ttc_pkg::CLS_PUNCT;

   // Pack the up to two results of this byte in text order.
   always_comb begin
      q_entry.first = close_v ? close_tok : (punct_v ? punct_tok : end_tok);
      q_entry.second = (close_v && punct_v) ? punct_tok : end_tok;
      q_entry.two = (close_v && (punct_v || end_v)) || (punct_v && end_v);
   end

   assign q_push = accept && (close_v || punct_v || end_v);

   always_comb begin
      mode_in = mode_ff;
      pos_in = pos_ff;
      start_in = start_ff;
      quote_in = quote_ff;
      kw_in = kw_ff;
      pend_in = pend_ff;
      if (accept) begin
         if (req_text_end) begin
            mode_in = MODE_IDLE;
            pos_in = '0;
            start_in = '0;
            quote_in = 1'b0;
            kw_in = 4'd0;
            pend_in = '0;
         end else begin
            mode_in = mode_mid;
            pos_in = nxt;
            start_in = start_mid;
            quote_in = quote_mid;
            kw_in = kw_mid;
            pend_in = pend_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff <= '0;
         start_ff <= '0;
         quote_ff <= 1'b0;
         kw_ff <= 4'd0;
         pend_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         start_ff <= start_in;
         quote_ff <= quote_in;
         kw_ff <= kw_in;
         pend_ff <= pend_in;
      end
   end

endmodule

>>> rtl/ttc_queue.sv
`include "assert_macros.svh"

module ttc_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  ttc_pkg::entry_type push_entry,
   input  logic pop,
   output ttc_pkg::entry_type head_entry,
   output ttc_pkg::q_status_type status
);

   ttc_pkg::entry_type entries_ff [ttc_pkg::QUEUE_DEPTH];
   logic [ttc_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [ttc_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign status.full = (count_ff == ttc_pkg::QCNT_W'(ttc_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop = pop && !status.empty;
   assign head_entry = entries_ff[rd_ff];

   always_comb begin
      wr_in = do_push ? wr_ff + ttc_pkg::QPTR_W'(1) : wr_ff;
      rd_in = do_pop ? rd_ff + ttc_pkg::QPTR_W'(1) : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + ttc_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - ttc_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ff] <= push_entry;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= ttc_pkg::QCNT_W'(ttc_pkg::QUEUE_DEPTH))
   `ASSERT_IMPLY(a_no_push_full, clock, reset, push, !status.full)
   `ASSERT_IMPLY(a_no_pop_empty, clock, reset, pop, !status.empty)
   `ASSERT_IMPLY(a_ptr_count, clock, reset, !status.full,
      (wr_ff - rd_ff) == count_ff[ttc_pkg::QPTR_W-1:0])

endmodule

>>> rtl/ttc_back.sv
module ttc_back (
   input  logic clock,
   input  logic reset,
   input  ttc_pkg::q_status_type q_status,
   input  ttc_pkg::entry_type head_entry,
   output logic q_pop,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [ttc_pkg::POS_W-1:0] rsp_token_start,
   output logic [ttc_pkg::POS_W-1:0] rsp_token_stop,
   output logic [2:0] rsp_token_class,
   output logic rsp_run_last
);

   ttc_pkg::entry_type cur_ff, cur_in;
   logic valid_ff, valid_in;
   logic second_ff, second_in;
   logic taken, done;
   ttc_pkg::token_type shown;

   assign taken = rsp_pop && valid_ff;
   assign done = second_ff || !cur_ff.two;
   assign q_pop = !q_status.empty && (!valid_ff || (taken && done));

   assign shown = second_ff ? cur_ff.second : cur_ff.first;
   assign rsp_empty = !valid_ff;
   assign rsp_token_start = shown.start;
   assign rsp_token_stop = shown.stop;
   assign rsp_token_class = shown.cls;
   assign rsp_run_last = done;

   always_comb begin
      cur_in = cur_ff;
      valid_in = valid_ff;
      second_in = second_ff;
      if (q_pop) begin
         cur_in = head_entry;
         valid_in = 1'b1;
         second_in = 1'b0;
      end else if (taken) begin
         if (done) begin
            valid_in = 1'b0;
            second_in = 1'b0;
         end else begin
            second_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

>>> rtl/config_text_token_classifier_core.sv
// Token classifier for configuration text.
// Input: one text byte per transaction on req_text_byte, with req_text_end high
// on the final byte of a text. A transaction is taken when req_push is high and
// req_full is low; one byte can be taken every cycle.
// Output: token spans (start, exclusive stop, class) in text order. The oldest
// span is on the rsp_ ports while rsp_empty is low and leaves when rsp_pop is
// high. rsp_run_last marks the last span caused by a byte. A byte causes zero,
// one or two spans.
// The spans of a taken byte are registered in the queue and then in the output
// register of the back end before they show on the rsp_ ports. The front
// scanner classifies a byte combinationally and writes its spans to a four-entry
// queue; the back end presents one span per cycle while the receiver pops.
// Throughput is one byte per cycle while bytes cause at most one span on average
// and the receiver pops every cycle, as the output moves one span per cycle.
// When the receiver stalls, the queue fills and req_full rises; nothing is lost.
// Reset clears the scanner to the start of a new text at position 0 and
// empties the queue and the output stage.
module config_text_token_classifier_core (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic [7:0] req_text_byte,
   input  logic req_text_end,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [12:0] rsp_token_start,
   output logic [12:0] rsp_token_stop,
   output logic [2:0] rsp_token_class,
   output logic rsp_run_last
);

   ttc_pkg::q_status_type q_status;
   ttc_pkg::entry_type push_entry, head_entry;
   logic q_push, q_pop;

   ttc_front u_front (
      .clock(clock),
      .reset(reset),
      .req_text_byte(req_text_byte),
      .req_text_end(req_text_end),
      .req_push(req_push),
      .req_full(req_full),
      .q_status(q_status),
      .q_push(q_push),
      .q_entry(push_entry)
   );

   ttc_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_entry(push_entry),
      .pop(q_pop),
      .head_entry(head_entry),
      .status(q_status)
   );

   ttc_back u_back (
      .clock(clock),
      .reset(reset),
      .q_status(q_status),
      .head_entry(head_entry),
      .q_pop(q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_token_start(rsp_token_start),
      .rsp_token_stop(rsp_token_stop),
      .rsp_token_class(rsp_token_class),
      .rsp_run_last(rsp_run_last)
   );

endmodule

>>> sim/config_text_token_classifier_core_test.sv
`timescale 1ns / 100ps

module config_text_token_classifier_core_test;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_STRING,
      SCAN_ESCAPE,
      SCAN_CLOSED,
      SCAN_NUMBER,
      SCAN_WORD
   } scan_state_type;

   typedef struct {
      logic [ttc_pkg::POS_W-1:0] start;
      logic [ttc_pkg::POS_W-1:0] stop;
      logic [2:0] cls;
      logic last;
   } span_type;

   localparam int unsigned CYCLE_LIMIT = 1_500_000;
   localparam int unsigned RANDOM_ITEMS = 1750;

   class token_scoreboard;
      scan_state_type state;
      logic [ttc_pkg::POS_W-1:0] position;
      logic [ttc_pkg::POS_W-1:0] token_begin;
      logic [ttc_pkg::POS_W-1:0] string_end;
      logic single_quote;
      logic [3:0] word_match;
      string keyword_text = "config";
      span_type expected_spans[$];
      int unsigned mismatches;

      function new();
         clear();
         mismatches = 0;
      endfunction

      // State after reset and after the final byte of every text.
      function void clear();
         state = SCAN_IDLE;
         position = '0;
         token_begin = '0;
         string_end = '0;
         single_quote = 1'b0;
         word_match = '0;
      endfunction

      function void add_span(logic [ttc_pkg::POS_W-1:0] start,
                             logic [ttc_pkg::POS_W-1:0] stop, logic [2:0] cls);
         span_type s;
         s.start = start;
         s.stop = stop;
         s.cls = cls;
         s.last = 1'b0;
         expected_spans = {expected_spans, s};
      endfunction

      function bit digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit word_first(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
      endfunction

      function bit punct(logic [7:0] c);
         return c == "{" || c == "}" || c == "[" || c == "]" || c == "," ||
                c == ttc_pkg::CH_COLON || c == "=";
      endfunction

      function void match_step(logic [7:0] c);
         if (word_match < ttc_pkg::KW_LEN && c == keyword_text[word_match]) begin
            word_match = word_match + 4'd1;
         end else begin
            word_match = ttc_pkg::KW_FAIL;
         end
      endfunction

      // A byte seen with no token open may open one or be a punctuation token.
      function void start_token(logic [7:0] c, logic [ttc_pkg::POS_W-1:0] here);
         state = SCAN_IDLE;
         if (c == ttc_pkg::CH_DQUOTE || c == ttc_pkg::CH_SQUOTE) begin
            state = SCAN_STRING;
            token_begin = here;
            single_quote = (c == ttc_pkg::CH_SQUOTE);
         end else if (digit(c)) begin
            state = SCAN_NUMBER;
            token_begin = here;
         end else if (word_first(c)) begin
            state = SCAN_WORD;
            token_begin = here;
            word_match = '0;
            match_step(c);
         end else if (punct(c)) begin
            add_span(here, (here >= ttc_pkg::MAX_POS) ? ttc_pkg::MAX_POS : here + 1'b1,
                     ttc_pkg::CLS_PUNCT);
         end
      endfunction

      function void note_byte(logic [7:0] c, logic last_byte);
         logic [ttc_pkg::POS_W-1:0] here;
         logic [ttc_pkg::POS_W-1:0] next_at;
         logic [7:0] closing;
         int first_new;
         here = position;
         next_at = (here >= ttc_pkg::MAX_POS) ? ttc_pkg::MAX_POS : here + 1'b1;
         closing = single_quote ? ttc_pkg::CH_SQUOTE : ttc_pkg::CH_DQUOTE;
         first_new = expected_spans.size();
         case (state)
            SCAN_STRING: begin
               if (c == ttc_pkg::CH_BSLASH) begin
                  state = SCAN_ESCAPE;
               end else if (c == closing) begin
                  string_end = next_at;
                  state = SCAN_CLOSED;
               end
            end
            SCAN_ESCAPE: begin
               state = SCAN_STRING;
            end
            SCAN_CLOSED: begin
               // The first byte past blanks decides between key and value.
               if (c != ttc_pkg::CH_SPACE && c != ttc_pkg::CH_TAB) begin
                  add_span(token_begin, string_end,
                           (c == ttc_pkg::CH_COLON) ? ttc_pkg::CLS_KEY : ttc_pkg::CLS_VALUE);
                  start_token(c, here);
               end
            end
            SCAN_NUMBER: begin
               if (!digit(c)) begin
                  add_span(token_begin, here, ttc_pkg::CLS_NUMBER);
                  start_token(c, here);
               end
            end
            SCAN_WORD: begin
               if (word_first(c) || digit(c)) begin
                  match_step(c);
               end else begin
                  if (word_match == ttc_pkg::KW_LEN) begin
                     add_span(token_begin, here, ttc_pkg::CLS_KEYWORD);
                  end
                  start_token(c, here);
               end
            end
            default: begin
               start_token(c, here);
            end
         endcase
         if (last_byte) begin
            case (state)
               SCAN_STRING, SCAN_ESCAPE: add_span(token_begin, next_at, ttc_pkg::CLS_VALUE);
               SCAN_CLOSED: add_span(token_begin, string_end, ttc_pkg::CLS_VALUE);
               SCAN_NUMBER: add_span(token_begin, next_at, ttc_pkg::CLS_NUMBER);
               SCAN_WORD: begin
                  if (word_match == ttc_pkg::KW_LEN) begin
                     add_span(token_begin, next_at, ttc_pkg::CLS_KEYWORD);
                  end
               end
               default: begin
               end
            endcase
            clear();
         end else begin
            position = next_at;
         end
         if (expected_spans.size() > first_new) begin
            expected_spans[expected_spans.size() - 1].last = 1'b1;
         end
      endfunction

      function void check_span(logic [ttc_pkg::POS_W-1:0] got_start,
                               logic [ttc_pkg::POS_W-1:0] got_stop,
                               logic [2:0] got_cls, logic got_last);
         span_type want;
         if (expected_spans.size() == 0) begin
            $display("%0t: unexpected token start=%0d stop=%0d class=%0d last=%0d",
                     $time, got_start, got_stop, got_cls, got_last);
            mismatches++;
            return;
         end
         want = expected_spans.pop_front();
         if (got_start !== want.start) begin
            $display("%0t: token start expected %0d, actual %0d", $time, want.start, got_start);
            mismatches++;
         end
         if (got_stop !== want.stop) begin
            $display("%0t: token stop expected %0d, actual %0d", $time, want.stop, got_stop);
            mismatches++;
         end
         if (got_cls !== want.cls) begin
            $display("%0t: token class expected %0d, actual %0d", $time, want.cls, got_cls);
            mismatches++;
         end
         if (got_last !== want.last) begin
            $display("%0t: run_last expected %0d, actual %0d", $time, want.last, got_last);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_spans.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [7:0] req_text_byte = '0;
   logic req_text_end = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [12:0] rsp_token_start;
   logic [12:0] rsp_token_stop;
   logic [2:0] rsp_token_class;
   logic rsp_run_last;

   token_scoreboard spans;
   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned pop_mode = 0;
   int unsigned pop_hold = 0;
   logic [15:0] pop_pattern = 16'hffff;
   logic [7:0] text_buf[$];

   config_text_token_classifier_core dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_text_byte(req_text_byte),
      .req_text_end(req_text_end),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_token_start(rsp_token_start),
      .rsp_token_stop(rsp_token_stop),
      .rsp_token_class(rsp_token_class),
      .rsp_run_last(rsp_run_last)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("config_text_token_classifier_core_test NOT OK");
         $finish;
      end
   end

   // The receiver switches between popping freely, a rotating stall pattern and
   // sparse random pops.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            spans.check_span(rsp_token_start, rsp_token_stop, rsp_token_class, rsp_run_last);
         end
         if (pop_hold == 0) begin
            pop_mode = $urandom_range(0, 3);
            pop_pattern = 16'($urandom);
            pop_hold = $urandom_range(30, 300);
         end
         pop_hold = pop_hold - 1;
         pop_pattern = {pop_pattern[14:0], pop_pattern[15]};
         case (pop_mode)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= pop_pattern[0];
            2: rsp_pop <= ($urandom_range(0, 3) == 0);
            default: rsp_pop <= pop_pattern[0] | pop_pattern[1];
         endcase
      end
   end

   task automatic put_byte(input logic [7:0] b);
      text_buf = {text_buf, b};
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last_byte);
      req_push <= 1'b1;
      req_text_byte <= b;
      req_text_end <= last_byte;
      @(posedge clock);
      while (req_full) @(posedge clock);
      spans.note_byte(b, last_byte);
      if (burst_left == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                  : $urandom_range(1, 12);
      end else begin
         burst_left--;
      end
   endtask

   task automatic add_chars(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   // Sends the buffered text with the end flag on its final byte.
   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++) begin
         send_byte(text_buf[i], i == text_buf.size() - 1);
      end
      text_buf.delete();
   endtask

   task automatic add_blanks(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         put_byte($urandom_range(0, 1) ? ttc_pkg::CH_SPACE : ttc_pkg::CH_TAB);
      end
   endtask

   task automatic add_random_token();
      string punct_set;
      string near_words[5];
      logic [7:0] quote;
      int unsigned len;
      punct_set = "{}[],:=";
      near_words = '{"conf", "configs", "Config", "config_2", "cconfig"};
      case ($urandom_range(0, 11))
         0, 1: add_chars("config");
         2: add_chars(near_words[$urandom_range(0, 4)]);
         3: begin
            len = $urandom_range(1, 6);
            put_byte(($urandom_range(0, 3) == 0) ? 8'("_") : 8'("a" + $urandom_range(0, 25)));
            for (int unsigned i = 1; i < len; i++) begin
               case ($urandom_range(0, 3))
                  0: put_byte(8'("0" + $urandom_range(0, 9)));
                  1: put_byte(8'("A" + $urandom_range(0, 25)));
                  2: put_byte(8'("_"));
                  default: put_byte(8'("a" + $urandom_range(0, 25)));
               endcase
            end
         end
         4: begin
            len = $urandom_range(1, 5);
            for (int unsigned i = 0; i < len; i++) put_byte(8'("0" + $urandom_range(0, 9)));
         end
         5, 6: begin
            quote = $urandom_range(0, 1) ? ttc_pkg::CH_SQUOTE : ttc_pkg::CH_DQUOTE;
            put_byte(quote);
            len = $urandom_range(0, 6);
            for (int unsigned i = 0; i < len; i++) begin
               case ($urandom_range(0, 5))
                  0: begin
                     put_byte(ttc_pkg::CH_BSLASH);
                     put_byte(8'($urandom_range(0, 255)));
                  end
                  1: put_byte((quote == ttc_pkg::CH_SQUOTE) ? ttc_pkg::CH_DQUOTE
                                                            : ttc_pkg::CH_SQUOTE);
                  default: put_byte(8'($urandom_range(32, 126)));
               endcase
            end
            // Leaving a string open lets it swallow the rest of the text.
            if ($urandom_range(0, 7) != 0) put_byte(quote);
            if ($urandom_range(0, 1)) begin
               add_blanks($urandom_range(0, 3));
               if ($urandom_range(0, 3) != 0) put_byte(ttc_pkg::CH_COLON);
            end
         end
         7, 8: put_byte(punct_set[$urandom_range(0, 6)]);
         9: add_blanks($urandom_range(1, 3));
         10: put_byte(8'($urandom_range(0, 255)));
         default: put_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(128, 255)));
      endcase
      if ($urandom_range(0, 1)) begin
         if ($urandom_range(0, 1)) put_byte(ttc_pkg::CH_SPACE);
         else put_byte(punct_set[$urandom_range(0, 6)]);
      end
   endtask

   initial begin
      int unsigned sent;
      int unsigned tokens;
      spans = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Punctuation, key string before a tab and colon, number, and a quoted
      // value with an escaped quote that is still waiting when the text ends.
      add_chars("{\"k\"\t:12,'v\\'x'");
      send_text();
      // Backslash as the final byte of an open string.
      add_chars("\"a\\");
      send_text();
      put_byte(8'hff);
      add_chars("9");
      send_text();
      // Keyword closed by the end of the text.
      add_chars("config");
      send_text();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 15) == 0) begin
            put_byte(8'($urandom_range(0, 255)));
         end else begin
            tokens = $urandom_range(1, 10);
            for (int unsigned i = 0; i < tokens; i++) add_random_token();
         end
         sent += text_buf.size();
         send_text();
      end

      // One long text so that tokens straddle the saturation point.
      add_blanks($urandom_range(4070, 4090));
      add_chars("\"ab\" : 1234567 config [");
      for (int unsigned i = 0; i < 8; i++) add_random_token();
      send_text();

      req_push <= 1'b0;
      while (spans.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (spans.mismatches == 0) begin
         $display("config_text_token_classifier_core_test OK");
      end else begin
         $display("config_text_token_classifier_core_test NOT OK");
      end
      $finish;
   end

endmodule

>>> config_text_token_classifier_core.f
+incdir+rtl
rtl/ttc_pkg.sv
rtl/ttc_front.sv
rtl/ttc_queue.sv
rtl/ttc_back.sv
rtl/config_text_token_classifier_core.sv
sim/config_text_token_classifier_core_test.sv
